// ===== rtl/core/byte_addressed_sized_memory_assert.svh =====
// assertion macros for the byte addressed sized memory checker
// no dependencies; included by the checker file
`ifndef BYTE_ADDRESSED_SIZED_MEMORY_ASSERT_SVH
`define BYTE_ADDRESSED_SIZED_MEMORY_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define BAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define BAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bas_pkg.sv =====
// shared types, constants and helpers for the byte addressed sized memory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

    localparam int unsigned CAPACITY_BYTES_DEF = 65536;
    localparam int unsigned NUM_LANES          = 4;
    localparam int unsigned SIZE_W             = 17;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 17'd65536;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        out_of_bounds;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic we;
    } t_lane_ctl;

    // byte count of an access; code three counts as a word
    function automatic logic [2:0] size_bytes(input logic [1:0] code);
        logic [2:0] n;
        unique case (code)
            SIZE_BYTE: n = 3'd1;
            SIZE_HALF: n = 3'd2;
            SIZE_WORD: n = 3'd4;
            default:   n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bas_bank.sv =====
// one byte-wide bank of the store, single port, registered read
// depends on bas_pkg
`timescale 1ns / 1ps
`default_nettype none

module bas_bank #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned ROW_W = 14
) (
    input  wire logic              i_clk,
    input  wire bas_pkg::t_lane_ctl i_ctl,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [7:0]        i_wdata,
    output logic [7:0]             o_rdata
);
    import bas_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_row] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_row];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/byte_addressed_sized_memory.sv =====
// top level of the byte addressed sized memory: bound check, lane steering, result assembly
// depends on bas_pkg and bas_bank
`timescale 1ns / 1ps
`default_nettype none

// Little-endian byte-addressed store taking byte, halfword and word reads or writes at
// any alignment. The store is split into four byte-wide banks by the low two address
// bits, so any access touches each bank at most once, and one transaction is accepted
// every cycle unless a stalled output holds it back. Results pass the bank read register,
// then the output register. An access with any byte at or beyond min(size_in_use,
// CAPACITY_BYTES) returns out_of_bounds with read_data zero and changes nothing; writes
// return zero. The store is not cleared at reset: bytes read before being written give
// unspecified data. The size register is written through the configuration channel,
// always ready, and should only change while no transaction is in flight.
module byte_addressed_sized_memory #(
    parameter int unsigned CAPACITY_BYTES = bas_pkg::CAPACITY_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire bas_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output bas_pkg::t_out_item               o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bas_pkg::SIZE_W-1:0]  i_cfg_data
);
    import bas_pkg::*;

    localparam int unsigned BANK_DEPTH = (CAPACITY_BYTES + NUM_LANES - 1) / NUM_LANES;
    localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int unsigned CAP_W      = $clog2(CAPACITY_BYTES + 1);
    localparam int unsigned LIM_W      = (CAP_W > SIZE_W) ? CAP_W : SIZE_W;
    localparam logic [LIM_W-1:0] CAP_LIM = LIM_W'(CAPACITY_BYTES);

    logic [SIZE_W-1:0] r_size_in_use;
    logic              r_s1_valid;
    logic              r_s1_op;
    logic              r_s1_oob;
    logic [1:0]        r_s1_off;
    logic [2:0]        r_s1_nbytes;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              n_s1_valid;
    logic              n_out_valid;
    t_out_item         n_out_data;

    logic              w_out_free;
    logic              w_s1_move;
    logic              w_in_accept;
    logic [LIM_W-1:0]  w_limit;
    logic [2:0]        w_nbytes;
    logic [32:0]       w_end;
    logic              w_oob;
    logic [7:0]        w_lane_rdata [NUM_LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_in_use <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size_in_use <= i_cfg_data;
        end
    end

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign o_in_stall  = r_s1_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_limit  = (LIM_W'(r_size_in_use) > CAP_LIM) ? CAP_LIM : LIM_W'(r_size_in_use);
    assign w_nbytes = size_bytes(i_in_data.access_size);
    assign w_end    = {1'b0, i_in_data.address} + 33'(w_nbytes);
    assign w_oob    = w_end > 33'(w_limit);

    for (genvar b = 0; b < NUM_LANES; b++) begin : g_lane
        logic [1:0]       w_k;
        logic [ROW_W-1:0] w_row;
        logic [31:0]      w_shifted;
        t_lane_ctl        w_ctl;

        assign w_k       = 2'(b) - i_in_data.address[1:0];
        assign w_row     = i_in_data.address[ROW_W+1:2]
                         + ROW_W'(2'(b) < i_in_data.address[1:0]);
        assign w_shifted = i_in_data.write_data >> {w_k, 3'b000};
        assign w_ctl.en  = w_in_accept && !w_oob && ({1'b0, w_k} < w_nbytes);
        assign w_ctl.we  = (i_in_data.op == OP_WRITE);

        bas_bank #(
            .DEPTH (BANK_DEPTH),
            .ROW_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_row   (w_row),
            .i_wdata (w_shifted[7:0]),
            .o_rdata (w_lane_rdata[b])
        );
    end

    always_comb begin
        logic [1:0] lane;
        n_out_data = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            lane = r_s1_off + 2'(k);
            if (3'(k) < r_s1_nbytes) begin
                n_out_data.read_data[8*k +: 8] = w_lane_rdata[lane];
            end
        end
        if (r_s1_oob || r_s1_op == OP_WRITE) begin
            n_out_data.read_data = '0;
        end
        n_out_data.out_of_bounds = r_s1_oob;
    end

    assign n_s1_valid  = w_in_accept || (r_s1_valid && !w_s1_move);
    assign n_out_valid = w_s1_move || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_op     <= i_in_data.op;
            r_s1_oob    <= w_oob;
            r_s1_off    <= i_in_data.address[1:0];
            r_s1_nbytes <= w_nbytes;
        end
        if (w_s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/bas_checker.sv =====
// port-level checker for the byte addressed sized memory, bound to the top level
// depends on bas_pkg and byte_addressed_sized_memory_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "byte_addressed_sized_memory_assert.svh"

module bas_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_stall,
    input wire logic               i_out_valid,
    input wire logic               i_out_stall,
    input wire bas_pkg::t_out_item i_out_data
);
    import bas_pkg::*;

    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && !i_in_stall;
    assign w_out_acc = i_out_valid && !i_out_stall;

    always_comb begin
        n_pend = r_pend + 2'(w_in_acc) - 2'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `BAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall,
        i_out_valid && $stable(i_out_data), "stalled result changed")
    `BAS_ASSERT_NOW(a_oob_zero, i_clk, i_rst_n, i_out_valid && i_out_data.out_of_bounds,
        i_out_data.read_data == 32'd0, "rejected access returned data")
    `BAS_ASSERT_NOW(a_pend_max, i_clk, i_rst_n, 1'b1, r_pend != 2'd3,
        "more than two transactions in flight")
    `BAS_ASSERT_NOW(a_out_owed, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0,
        "result without accepted transaction")
    `BAS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, i_in_stall,
        i_out_valid && i_out_stall, "input stalled while output free")

endmodule

bind byte_addressed_sized_memory bas_checker u_bas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
